// ===== rtl/core/cbf_pkg.sv =====
// Shared types and constants for the chunk boundary finder.
`default_nettype none
package cbf_pkg;

  localparam int unsigned HistLen = 10;
  localparam int unsigned CountW  = 17;
  localparam int unsigned OffsetW = 16;

  localparam logic [CountW-1:0]  CountMax       = '1;
  localparam logic [OffsetW-1:0] MaxOffsetReset = 16'hfff4;

  localparam logic [7:0] EopType  = 8'h82;
  localparam logic [7:0] TagByte  = 8'h07;
  localparam logic [7:0] MarkByte = 8'h84;
  localparam logic [7:0] HdrTypeA = 8'h64;
  localparam logic [7:0] HdrTypeB = 8'h40;
  localparam logic [7:0] HdrTypeC = 8'h42;

  typedef logic [HistLen-1:0][7:0] hist_t;

  // Window stage contents handed to the evaluate stage.
  typedef struct packed {
    hist_t             hist;    // entry 0 is the oldest byte
    logic [CountW-1:0] idx;     // byte index of the newest byte
    logic              last;
  } win_t;

endpackage
`default_nettype wire

// ===== rtl/core/cbf_if.sv =====
// Channel interfaces: input bytes, results, configuration writes.
`default_nettype none
interface cbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       window_end;
  modport source (output valid, output data_byte, output window_end, input ready);
  modport sink   (input valid, input data_byte, input window_end, output ready);
endinterface

interface cbf_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] boundary_offset;
  logic        end_of_page;
  modport source (output valid, output found, output boundary_offset,
                  output end_of_page, input ready);
  modport sink   (input valid, input found, input boundary_offset,
                  input end_of_page, output ready);
endinterface

interface cbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_offset;
  modport source (output valid, output max_offset, input ready);
  modport sink   (input valid, input max_offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cbf_window.sv =====
// Input stage: ten-byte history shift register and byte counter.
`default_nettype none
module cbf_window (
  input  wire logic     clk,
  input  wire logic     rst_n,
  cbf_in_if.sink        in_ch,
  input  wire logic     adv,
  output cbf_pkg::win_t win,
  output logic          win_vld
);

  cbf_pkg::hist_t                 hist_r, hist_nxt, base;
  logic [cbf_pkg::CountW-1:0]     idx_r, cnt_r, cnt_nxt;
  logic                           last_r, vld_r, clr_r;
  logic                           take;

  assign in_ch.ready = !vld_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    // Start from a cleared window after the previous window's last byte.
    base     = clr_r ? '0 : hist_r;
    hist_nxt = {in_ch.data_byte, base[cbf_pkg::HistLen-1:1]};
    cnt_nxt  = (cnt_r == cbf_pkg::CountMax) ? cnt_r : cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      clr_r <= 1'b1;
      cnt_r <= '0;
    end else begin
      if (take) begin
        vld_r <= 1'b1;
        clr_r <= in_ch.window_end;
        cnt_r <= in_ch.window_end ? '0 : cnt_nxt;
      end else if (adv) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hist_r <= hist_nxt;
      idx_r  <= cnt_r;
      last_r <= in_ch.window_end;
    end
  end

  assign win.hist = hist_r;
  assign win.idx  = idx_r;
  assign win.last = last_r;
  assign win_vld  = vld_r;

endmodule
`default_nettype wire

// ===== rtl/core/cbf_eval.sv =====
// Evaluate stage: pattern compare, offset check, result register.
`default_nettype none
module cbf_eval (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cbf_pkg::win_t                 win,
  input  wire logic                          win_vld,
  input  wire logic [cbf_pkg::OffsetW-1:0]   max_offset,
  output logic                               adv,
  cbf_out_if.source                          out_ch
);

  logic [cbf_pkg::CountW-1:0] p;
  logic common, is_eop, is_hdr, in_range, hit, miss;
  logic mr_r, mr_nxt;
  logic vld_r, found_r, eop_r;
  logic [cbf_pkg::OffsetW-1:0] off_r;

  assign adv = win_vld && (!vld_r || out_ch.ready);

  always_comb begin
    common = win.hist[1] == cbf_pkg::TagByte && win.hist[2] == 8'h00 &&
             win.hist[4] == 8'h00 && win.hist[5] == cbf_pkg::MarkByte &&
             win.hist[8] == 8'h00 && win.hist[9] == 8'h00;
    is_eop = common && win.hist[0] == cbf_pkg::EopType &&
             win.hist[6] == 8'h00 && win.hist[7] == 8'h00;
    is_hdr = common && (win.hist[0] == cbf_pkg::HdrTypeA ||
                        win.hist[0] == cbf_pkg::HdrTypeB ||
                        win.hist[0] == cbf_pkg::HdrTypeC);
    p        = win.idx - cbf_pkg::CountW'(cbf_pkg::HistLen - 1);
    in_range = (win.idx >= cbf_pkg::CountW'(cbf_pkg::HistLen)) &&
               (p <= {1'b0, max_offset});
    hit      = !mr_r && in_range && (is_eop || is_hdr);
    miss     = !mr_r && !hit && win.last;
    mr_nxt   = win.last ? 1'b0 : (mr_r || hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      mr_r  <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= hit || miss;
        mr_r  <= mr_nxt;
      end else if (out_ch.ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found_r <= hit;
      off_r   <= hit ? p[cbf_pkg::OffsetW-1:0] : '0;
      eop_r   <= hit && is_eop;
    end
  end

  assign out_ch.valid           = vld_r;
  assign out_ch.found           = found_r;
  assign out_ch.boundary_offset = off_r;
  assign out_ch.end_of_page     = eop_r;

endmodule
`default_nettype wire

// ===== rtl/core/chunk_boundary_finder.sv =====
// Top level of the chunk boundary finder.
//
//   channel  dir  payload                                  handshake
//   in_ch    in   data_byte[7:0], window_end               valid/ready
//   out_ch   out  found, boundary_offset[15:0], end_of_page valid/ready
//   cfg_ch   in   max_offset[15:0]                          valid/ready
//
// One byte per cycle sustained while out_ch is ready; a result passes the
// window register, then the result register. rst_n is synchronous: the
// byte counter and match flag clear, the next window starts cleared, and
// max_offset returns to 0xfff4. A stalled result holds the evaluate stage;
// the window stage still takes one more byte. cfg_ch is always ready.
`default_nettype none
module chunk_boundary_finder (
  input  wire logic clk,
  input  wire logic rst_n,
  cbf_in_if.sink    in_ch,
  cbf_out_if.source out_ch,
  cbf_cfg_if.sink   cfg_ch
);

  cbf_pkg::win_t                win;
  logic                         win_vld;
  logic                         adv;
  logic [cbf_pkg::OffsetW-1:0]  max_offset_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_offset_r <= cbf_pkg::MaxOffsetReset;
    end else if (cfg_ch.valid) begin
      max_offset_r <= cfg_ch.max_offset;
    end
  end

  cbf_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .adv     (adv),
    .win     (win),
    .win_vld (win_vld)
  );

  cbf_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .win        (win),
    .win_vld    (win_vld),
    .max_offset (max_offset_r),
    .adv        (adv),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
